[rtl/sm83_alu_with_flags_assert.svh]
// Assertion macros for the SM83 ALU block.
// The block using them must have signals named clk and rst in scope.
`ifndef SM83_ALU_WITH_FLAGS_ASSERT_SVH
`define SM83_ALU_WITH_FLAGS_ASSERT_SVH

// Check cons in the same cycle in which ante holds.
`define SM83_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante holds.
`define SM83_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sm83_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sm83_pkg;

  // Operation codes
  localparam logic [5:0] OP_ADD8  = 6'd0;
  localparam logic [5:0] OP_ADC   = 6'd1;
  localparam logic [5:0] OP_SUB   = 6'd2;
  localparam logic [5:0] OP_SBC   = 6'd3;
  localparam logic [5:0] OP_AND   = 6'd4;
  localparam logic [5:0] OP_XOR   = 6'd5;
  localparam logic [5:0] OP_OR    = 6'd6;
  localparam logic [5:0] OP_CP    = 6'd7;
  localparam logic [5:0] OP_INC8  = 6'd8;
  localparam logic [5:0] OP_DEC8  = 6'd9;
  localparam logic [5:0] OP_INC16 = 6'd10;
  localparam logic [5:0] OP_DEC16 = 6'd11;
  localparam logic [5:0] OP_ADD16 = 6'd12;
  localparam logic [5:0] OP_SPOFS = 6'd13;
  localparam logic [5:0] OP_DAA   = 6'd14;
  localparam logic [5:0] OP_CPL   = 6'd15;
  localparam logic [5:0] OP_SCF   = 6'd16;
  localparam logic [5:0] OP_CCF   = 6'd17;
  localparam logic [5:0] OP_RLCA  = 6'd18;
  localparam logic [5:0] OP_RRCA  = 6'd19;
  localparam logic [5:0] OP_RLA   = 6'd20;
  localparam logic [5:0] OP_RRA   = 6'd21;
  localparam logic [5:0] OP_RLC   = 6'd22;
  localparam logic [5:0] OP_RRC   = 6'd23;
  localparam logic [5:0] OP_RL    = 6'd24;
  localparam logic [5:0] OP_RR    = 6'd25;
  localparam logic [5:0] OP_SLA   = 6'd26;
  localparam logic [5:0] OP_SRA   = 6'd27;
  localparam logic [5:0] OP_SWAP  = 6'd28;
  localparam logic [5:0] OP_SRL   = 6'd29;
  localparam logic [5:0] OP_BIT   = 6'd30;
  localparam logic [5:0] OP_RES   = 6'd31;
  localparam logic [5:0] OP_SET   = 6'd32;

  // Flag positions inside the packed Z N H C nibble
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // Decimal adjust constants
  localparam logic [7:0] DAA_ADJ_LO    = 8'h06;
  localparam logic [7:0] DAA_ADJ_HI    = 8'h60;
  localparam logic [7:0] DAA_LIMIT     = 8'h99;
  localparam logic [3:0] BCD_DIGIT_MAX = 4'd9;

  // One input transaction
  typedef struct packed {
    logic [5:0]  opcode;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } req_item_t;

  // One result transaction
  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
    logic        writes_result;
  } rsp_item_t;

endpackage

`default_nettype wire

[rtl/sm83_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Operation channel
interface sm83_req_if;
  logic        valid;
  logic        ready;
  logic [5:0]  opcode;
  logic [15:0] operand_a;
  logic [15:0] operand_b;
  logic [2:0]  bit_index;
  logic [3:0]  flags_in;

  modport source (
    output valid, opcode, operand_a, operand_b, bit_index, flags_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, operand_a, operand_b, bit_index, flags_in,
    output ready
  );
endinterface

// Result channel
interface sm83_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result;
  logic [3:0]  flags_out;
  logic        writes_result;

  modport source (
    output valid, result, flags_out, writes_result,
    input  ready
  );
  modport sink (
    input  valid, result, flags_out, writes_result,
    output ready
  );
endinterface

`default_nettype wire

[rtl/sm83_exec.sv]
`timescale 1ns / 1ps
`default_nettype none

// Combinational ALU datapath: one operation in, result and flags out.
module sm83_exec (
  input  sm83_pkg::req_item_t item,
  output sm83_pkg::rsp_item_t res
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic [15:0] a16;
  logic [15:0] b16;
  logic        fz, fn, fh, fc;
  logic        carry_sel;
  logic [8:0]  add_sum;
  logic [4:0]  add_half;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_half;
  logic [7:0]  inc_r;
  logic [7:0]  dec_r;
  logic [16:0] add16_sum;
  logic [12:0] add16_half;
  logic [15:0] sp_sum;
  logic [4:0]  sp_half;
  logic [8:0]  sp_byte;
  logic        daa_lo;
  logic        daa_hi;
  logic [7:0]  daa_adj;
  logic [7:0]  daa_r;
  logic [7:0]  rlc_r, rrc_r, rl_r, rr_r, sla_r, sra_r, swap_r, srl_r;
  logic [7:0]  bit_mask;
  logic [7:0]  r8;
  logic        use_r8;
  logic [15:0] r16;
  logic [3:0]  f;
  logic        w;

  assign a16 = item.operand_a;
  assign b16 = item.operand_b;
  assign a   = item.operand_a[7:0];
  assign b   = item.operand_b[7:0];
  assign fz  = item.flags_in[sm83_pkg::FLAG_Z];
  assign fn  = item.flags_in[sm83_pkg::FLAG_N];
  assign fh  = item.flags_in[sm83_pkg::FLAG_H];
  assign fc  = item.flags_in[sm83_pkg::FLAG_C];

  // Carry/borrow in only for adc and sbc
  assign carry_sel = fc && (item.opcode == sm83_pkg::OP_ADC ||
                            item.opcode == sm83_pkg::OP_SBC);

  // 8-bit add and subtract with half carry
  assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, carry_sel};
  assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_sel};
  assign sub_diff = {1'b0, a} - {1'b0, b} - {8'd0, carry_sel};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, carry_sel};

  assign inc_r = a + 8'd1;
  assign dec_r = a - 8'd1;

  // 16-bit add, carries out of bit 11 and bit 15
  assign add16_sum  = {1'b0, a16} + {1'b0, b16};
  assign add16_half = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};

  // Stack pointer plus signed byte, flags from the low byte
  assign sp_sum  = a16 + {{8{b[7]}}, b};
  assign sp_half = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
  assign sp_byte = {1'b0, a16[7:0]} + {1'b0, b};

  // Decimal adjust after add or subtract
  assign daa_lo  = fh || (!fn && (a[3:0] > sm83_pkg::BCD_DIGIT_MAX));
  assign daa_hi  = fc || (!fn && (a > sm83_pkg::DAA_LIMIT));
  assign daa_adj = (daa_lo ? sm83_pkg::DAA_ADJ_LO : 8'd0) |
                   (daa_hi ? sm83_pkg::DAA_ADJ_HI : 8'd0);
  assign daa_r   = fn ? (a - daa_adj) : (a + daa_adj);

  // Rotates, shifts and swap
  assign rlc_r  = {a[6:0], a[7]};
  assign rrc_r  = {a[0], a[7:1]};
  assign rl_r   = {a[6:0], fc};
  assign rr_r   = {fc, a[7:1]};
  assign sla_r  = {a[6:0], 1'b0};
  assign sra_r  = {a[7], a[7:1]};
  assign swap_r = {a[3:0], a[7:4]};
  assign srl_r  = {1'b0, a[7:1]};

  assign bit_mask = 8'd1 << item.bit_index;

  // Select result and flags by operation
  always_comb begin
    r8     = 8'd0;
    use_r8 = 1'b1;
    r16    = 16'd0;
    f      = item.flags_in;
    w      = 1'b1;
    unique case (item.opcode) inside
      sm83_pkg::OP_ADD8, sm83_pkg::OP_ADC: begin
        r8 = add_sum[7:0];
        f  = {(add_sum[7:0] == 8'd0), 1'b0, add_half[4], add_sum[8]};
      end
      sm83_pkg::OP_SUB, sm83_pkg::OP_SBC: begin
        r8 = sub_diff[7:0];
        f  = {(sub_diff[7:0] == 8'd0), 1'b1, sub_half[4], sub_diff[8]};
      end
      sm83_pkg::OP_CP: begin
        w = 1'b0;
        f = {(sub_diff[7:0] == 8'd0), 1'b1, sub_half[4], sub_diff[8]};
      end
      sm83_pkg::OP_AND: begin
        r8 = a & b;
        f  = {((a & b) == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      sm83_pkg::OP_XOR: begin
        r8 = a ^ b;
        f  = {((a ^ b) == 8'd0), 3'b000};
      end
      sm83_pkg::OP_OR: begin
        r8 = a | b;
        f  = {((a | b) == 8'd0), 3'b000};
      end
      sm83_pkg::OP_INC8: begin
        r8 = inc_r;
        f  = {(inc_r == 8'd0), 1'b0, (inc_r[3:0] == 4'h0), fc};
      end
      sm83_pkg::OP_DEC8: begin
        r8 = dec_r;
        f  = {(dec_r == 8'd0), 1'b1, (dec_r[3:0] == 4'hF), fc};
      end
      sm83_pkg::OP_INC16: begin
        use_r8 = 1'b0;
        r16    = a16 + 16'd1;
      end
      sm83_pkg::OP_DEC16: begin
        use_r8 = 1'b0;
        r16    = a16 - 16'd1;
      end
      sm83_pkg::OP_ADD16: begin
        use_r8 = 1'b0;
        r16    = add16_sum[15:0];
        f      = {fz, 1'b0, add16_half[12], add16_sum[16]};
      end
      sm83_pkg::OP_SPOFS: begin
        use_r8 = 1'b0;
        r16    = sp_sum;
        f      = {2'b00, sp_half[4], sp_byte[8]};
      end
      sm83_pkg::OP_DAA: begin
        r8 = daa_r;
        f  = {(daa_r == 8'd0), fn, 1'b0, daa_hi};
      end
      sm83_pkg::OP_CPL: begin
        r8 = ~a;
        f  = {fz, 1'b1, 1'b1, fc};
      end
      sm83_pkg::OP_SCF: begin
        w = 1'b0;
        f = {fz, 1'b0, 1'b0, 1'b1};
      end
      sm83_pkg::OP_CCF: begin
        w = 1'b0;
        f = {fz, 1'b0, 1'b0, !fc};
      end
      // Accumulator rotates always clear Z
      sm83_pkg::OP_RLCA: begin
        r8 = rlc_r;
        f  = {3'b000, a[7]};
      end
      sm83_pkg::OP_RRCA: begin
        r8 = rrc_r;
        f  = {3'b000, a[0]};
      end
      sm83_pkg::OP_RLA: begin
        r8 = rl_r;
        f  = {3'b000, a[7]};
      end
      sm83_pkg::OP_RRA: begin
        r8 = rr_r;
        f  = {3'b000, a[0]};
      end
      sm83_pkg::OP_RLC: begin
        r8 = rlc_r;
        f  = {(rlc_r == 8'd0), 2'b00, a[7]};
      end
      sm83_pkg::OP_RRC: begin
        r8 = rrc_r;
        f  = {(rrc_r == 8'd0), 2'b00, a[0]};
      end
      sm83_pkg::OP_RL: begin
        r8 = rl_r;
        f  = {(rl_r == 8'd0), 2'b00, a[7]};
      end
      sm83_pkg::OP_RR: begin
        r8 = rr_r;
        f  = {(rr_r == 8'd0), 2'b00, a[0]};
      end
      sm83_pkg::OP_SLA: begin
        r8 = sla_r;
        f  = {(sla_r == 8'd0), 2'b00, a[7]};
      end
      sm83_pkg::OP_SRA: begin
        r8 = sra_r;
        f  = {(sra_r == 8'd0), 2'b00, a[0]};
      end
      sm83_pkg::OP_SWAP: begin
        r8 = swap_r;
        f  = {(swap_r == 8'd0), 3'b000};
      end
      sm83_pkg::OP_SRL: begin
        r8 = srl_r;
        f  = {(srl_r == 8'd0), 2'b00, a[0]};
      end
      sm83_pkg::OP_BIT: begin
        w = 1'b0;
        f = {((a & bit_mask) == 8'd0), 1'b0, 1'b1, fc};
      end
      sm83_pkg::OP_RES: begin
        r8 = a & ~bit_mask;
      end
      sm83_pkg::OP_SET: begin
        r8 = a | bit_mask;
      end
      // Unused codes: no operation, flags pass through
      default: begin
        w = 1'b0;
      end
    endcase
  end

  assign res.result        = use_r8 ? {8'd0, r8} : r16;
  assign res.flags_out     = f;
  assign res.writes_result = w;

endmodule

`default_nettype wire

[rtl/sm83_alu_with_flags.sv]
`timescale 1ns / 1ps
`default_nettype none

// SM83 ALU with Z/N/H/C flags. Each transaction on req carries an opcode,
// two 16-bit operands, a bit index and the current flags; exactly one
// transaction comes back on rsp with the result, the new flags and the
// write-back strobe. The block holds no architectural state. An operation
// is captured in an input register, evaluated by a single combinational
// pass through the ALU datapath and caught in a result register, which
// drives rsp. A new request is taken every cycle as long as rsp keeps
// draining. When rsp stalls, req drops ready as soon as the input register
// holds a request that cannot advance, so at most two transactions wait
// inside the block.
module sm83_alu_with_flags (
  input  wire           clk,
  input  wire           rst,
  sm83_req_if.sink      req,
  sm83_rsp_if.source    rsp
);

  `include "sm83_alu_with_flags_assert.svh"

  sm83_pkg::req_item_t req_item;
  sm83_pkg::req_item_t stage_item;
  logic                stage_valid;
  logic                stage_adv;
  sm83_pkg::rsp_item_t exec_res;
  sm83_pkg::rsp_item_t out_item;
  logic                out_valid;

  // Pack the incoming payload
  assign req_item.opcode    = req.opcode;
  assign req_item.operand_a = req.operand_a;
  assign req_item.operand_b = req.operand_b;
  assign req_item.bit_index = req.bit_index;
  assign req_item.flags_in  = req.flags_in;

  // Advance when the result register is free or being drained
  assign stage_adv = !out_valid || rsp.ready;
  assign req.ready = !stage_valid || stage_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage_item <= req_item;
    end
  end

  sm83_exec u_exec (
    .item (stage_item),
    .res  (exec_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_adv) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && stage_adv) begin
      out_item <= exec_res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.result        = out_item.result;
  assign rsp.flags_out     = out_item.flags_out;
  assign rsp.writes_result = out_item.writes_result;

  // Checks
  `SM83_ASSERT_SAME(a_no_accept_when_full, stage_valid && !stage_adv, !req.ready,
                    "request accepted while input register is blocked")
  `SM83_ASSERT_NEXT(a_accept_fills_stage, req.valid && req.ready, stage_valid,
                    "accepted request did not reach the input register")
  `SM83_ASSERT_NEXT(a_stage_to_output, stage_valid && stage_adv,
                    rsp.valid && rsp.result == $past(exec_res.result),
                    "evaluated operation did not reach the result register")
  `SM83_ASSERT_SAME(a_no_write_zero, rsp.valid && !rsp.writes_result,
                    rsp.result == 16'd0,
                    "result not zero for an operation without write-back")

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import sm83_pkg::*;

  // Opcodes past OP_SET decode as no-ops
  localparam logic [5:0] OP_UNUSED_LO = 6'd33;
  localparam logic [5:0] OP_UNUSED_HI = 6'd63;
  localparam int DIR_ROWS  = 25;
  localparam int RAND_OPS  = 1525;
  localparam int MAX_SHOWN = 50;

  typedef struct packed {
    req_item_t stim;
    logic      typed;
    rsp_item_t want;
  } dir_row_t;

  // Typed-in expectation travels with the transaction until it is accepted
  typedef struct packed {
    logic      typed;
    rsp_item_t want;
  } issue_note_t;

  logic clk;
  logic rst;

  sm83_req_if req_ch ();
  sm83_rsp_if rsp_ch ();

  sm83_alu_with_flags u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  issue_note_t issued_q[$];
  rsp_item_t   due_rsp_q[$];
  int          err_cnt = 0;
  int          burst_left = 0;

  // Directed rows; flags nibbles read Z N H C
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{OP_ADD8,  16'h0000, 16'h0000, 3'd0, 4'h0}, 1'b1, '{16'h0000, 4'b1000, 1'b1}},
    '{'{OP_ADD8,  16'h00FF, 16'h0001, 3'd0, 4'h0}, 1'b1, '{16'h0000, 4'b1011, 1'b1}},
    '{'{OP_ADC,   16'h00FF, 16'h00FF, 3'd0, 4'h1}, 1'b0, '{16'h0000, 4'b0000, 1'b0}},
    '{'{OP_SUB,   16'h0000, 16'h0001, 3'd0, 4'h0}, 1'b1, '{16'h00FF, 4'b0111, 1'b1}},
    '{'{OP_SBC,   16'h1234, 16'h0034, 3'd0, 4'h1}, 1'b0, '{16'h0000, 4'b0000, 1'b0}},
    '{'{OP_AND,   16'hFFFF, 16'hFFFF, 3'd0, 4'h0}, 1'b1, '{16'h00FF, 4'b0010, 1'b1}},
    '{'{OP_XOR,   16'h00AA, 16'h00AA, 3'd0, 4'h0}, 1'b1, '{16'h0000, 4'b1000, 1'b1}},
    '{'{OP_OR,    16'h0000, 16'h0000, 3'd0, 4'hF}, 1'b1, '{16'h0000, 4'b1000, 1'b1}},
    '{'{OP_CP,    16'h0042, 16'h0042, 3'd0, 4'h0}, 1'b1, '{16'h0000, 4'b1100, 1'b0}},
    '{'{OP_INC8,  16'h00FF, 16'h0000, 3'd0, 4'h1}, 1'b1, '{16'h0000, 4'b1011, 1'b1}},
    '{'{OP_DEC8,  16'h0000, 16'h0000, 3'd0, 4'h0}, 1'b1, '{16'h00FF, 4'b0110, 1'b1}},
    '{'{OP_INC16, 16'hFFFF, 16'h0000, 3'd0, 4'hA}, 1'b1, '{16'h0000, 4'b1010, 1'b1}},
    '{'{OP_DEC16, 16'h0000, 16'h0000, 3'd0, 4'h5}, 1'b1, '{16'hFFFF, 4'b0101, 1'b1}},
    '{'{OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'h8}, 1'b1, '{16'h0000, 4'b1011, 1'b1}},
    '{'{OP_SPOFS, 16'hFFF8, 16'h0080, 3'd0, 4'hF}, 1'b0, '{16'h0000, 4'b0000, 1'b0}},
    '{'{OP_SPOFS, 16'h00FF, 16'h0001, 3'd0, 4'h0}, 1'b1, '{16'h0100, 4'b0011, 1'b1}},
    '{'{OP_DAA,   16'h009A, 16'h0000, 3'd0, 4'h0}, 1'b1, '{16'h0000, 4'b1001, 1'b1}},
    '{'{OP_DAA,   16'h0000, 16'h0000, 3'd0, 4'h7}, 1'b1, '{16'h009A, 4'b0101, 1'b1}},
    '{'{OP_CPL,   16'h0000, 16'h0000, 3'd0, 4'h0}, 1'b1, '{16'h00FF, 4'b0110, 1'b1}},
    '{'{OP_SCF,   16'h0055, 16'h0000, 3'd0, 4'hE}, 1'b1, '{16'h0000, 4'b1001, 1'b0}},
    '{'{OP_CCF,   16'h0055, 16'h0000, 3'd0, 4'hF}, 1'b1, '{16'h0000, 4'b1000, 1'b0}},
    '{'{OP_RLCA,  16'h0000, 16'h0000, 3'd0, 4'h8}, 1'b1, '{16'h0000, 4'b0000, 1'b1}},
    '{'{OP_RRA,   16'h0001, 16'h0000, 3'd0, 4'h1}, 1'b0, '{16'h0000, 4'b0000, 1'b0}},
    '{'{OP_BIT,   16'h0080, 16'h0000, 3'd7, 4'h1}, 1'b1, '{16'h0000, 4'b0011, 1'b0}},
    '{'{OP_UNUSED_HI, 16'hFFFF, 16'hFFFF, 3'd7, 4'hF}, 1'b1,
      '{16'h0000, 4'b1111, 1'b0}}
  };

  // Compute the result transaction for one operation
  function automatic rsp_item_t alu_eval(input req_item_t op);
    rsp_item_t   r;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  v8;
    logic [7:0]  adj;
    logic [15:0] v16;
    logic [8:0]  s9;
    logic [4:0]  s5;
    logic [16:0] s17;
    logic [12:0] s13;
    logic        z, n, h, c, cin, t, wb, is8, dc;
    a   = op.operand_a[7:0];
    b   = op.operand_b[7:0];
    z   = op.flags_in[FLAG_Z];
    n   = op.flags_in[FLAG_N];
    h   = op.flags_in[FLAG_H];
    c   = op.flags_in[FLAG_C];
    cin = c;
    v8  = 8'h00;
    v16 = 16'h0000;
    wb  = 1'b1;
    is8 = 1'b1;
    case (op.opcode)
      OP_ADD8, OP_ADC: begin
        t  = (op.opcode == OP_ADC) ? cin : 1'b0;
        s9 = {1'b0, a} + {1'b0, b} + {8'd0, t};
        s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
        v8 = s9[7:0];
        z = (v8 == 8'h00); n = 1'b0; h = s5[4]; c = s9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        t  = (op.opcode == OP_SBC) ? cin : 1'b0;
        s9 = {1'b0, a} - {1'b0, b} - {8'd0, t};
        s5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
        v8 = s9[7:0];
        z = (v8 == 8'h00); n = 1'b1; h = s5[4]; c = s9[8];
        if (op.opcode == OP_CP) begin
          v8 = 8'h00;
          wb = 1'b0;
        end
      end
      OP_AND: begin
        v8 = a & b;
        z = (v8 == 8'h00); n = 1'b0; h = 1'b1; c = 1'b0;
      end
      OP_XOR, OP_OR: begin
        v8 = (op.opcode == OP_XOR) ? (a ^ b) : (a | b);
        z = (v8 == 8'h00); n = 1'b0; h = 1'b0; c = 1'b0;
      end
      OP_INC8: begin
        v8 = a + 8'd1;
        z = (v8 == 8'h00); n = 1'b0; h = (v8[3:0] == 4'h0);
      end
      OP_DEC8: begin
        v8 = a - 8'd1;
        z = (v8 == 8'h00); n = 1'b1; h = (v8[3:0] == 4'hF);
      end
      OP_INC16: begin
        is8 = 1'b0;
        v16 = op.operand_a + 16'd1;
      end
      OP_DEC16: begin
        is8 = 1'b0;
        v16 = op.operand_a - 16'd1;
      end
      OP_ADD16: begin
        is8 = 1'b0;
        s17 = {1'b0, op.operand_a} + {1'b0, op.operand_b};
        s13 = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
        v16 = s17[15:0];
        n = 1'b0; h = s13[12]; c = s17[16];
      end
      OP_SPOFS: begin
        is8 = 1'b0;
        v16 = op.operand_a + {{8{b[7]}}, b};
        s5  = {1'b0, op.operand_a[3:0]} + {1'b0, b[3:0]};
        s9  = {1'b0, op.operand_a[7:0]} + {1'b0, b};
        z = 1'b0; n = 1'b0; h = s5[4]; c = s9[8];
      end
      OP_DAA: begin
        adj = 8'h00;
        dc  = 1'b0;
        if (h || (!n && a[3:0] > BCD_DIGIT_MAX)) adj = DAA_ADJ_LO;
        if (c || (!n && a > DAA_LIMIT)) begin
          adj = adj | DAA_ADJ_HI;
          dc  = 1'b1;
        end
        v8 = n ? (a - adj) : (a + adj);
        z = (v8 == 8'h00); h = 1'b0; c = dc;
      end
      OP_CPL: begin
        v8 = ~a;
        n = 1'b1; h = 1'b1;
      end
      OP_SCF: begin
        wb = 1'b0;
        n = 1'b0; h = 1'b0; c = 1'b1;
      end
      OP_CCF: begin
        wb = 1'b0;
        n = 1'b0; h = 1'b0; c = !c;
      end
      OP_RLCA, OP_RLC: begin
        v8 = {a[6:0], a[7]};
        z = (op.opcode == OP_RLC) && (v8 == 8'h00); n = 1'b0; h = 1'b0; c = a[7];
      end
      OP_RRCA, OP_RRC: begin
        v8 = {a[0], a[7:1]};
        z = (op.opcode == OP_RRC) && (v8 == 8'h00); n = 1'b0; h = 1'b0; c = a[0];
      end
      OP_RLA, OP_RL: begin
        v8 = {a[6:0], cin};
        z = (op.opcode == OP_RL) && (v8 == 8'h00); n = 1'b0; h = 1'b0; c = a[7];
      end
      OP_RRA, OP_RR: begin
        v8 = {cin, a[7:1]};
        z = (op.opcode == OP_RR) && (v8 == 8'h00); n = 1'b0; h = 1'b0; c = a[0];
      end
      OP_SLA: begin
        v8 = {a[6:0], 1'b0};
        z = (v8 == 8'h00); n = 1'b0; h = 1'b0; c = a[7];
      end
      OP_SRA: begin
        v8 = {a[7], a[7:1]};
        z = (v8 == 8'h00); n = 1'b0; h = 1'b0; c = a[0];
      end
      OP_SWAP: begin
        v8 = {a[3:0], a[7:4]};
        z = (v8 == 8'h00); n = 1'b0; h = 1'b0; c = 1'b0;
      end
      OP_SRL: begin
        v8 = {1'b0, a[7:1]};
        z = (v8 == 8'h00); n = 1'b0; h = 1'b0; c = a[0];
      end
      OP_BIT: begin
        wb = 1'b0;
        z = !a[op.bit_index]; n = 1'b0; h = 1'b1;
      end
      OP_RES: v8 = a & ~(8'h01 << op.bit_index);
      OP_SET: v8 = a | (8'h01 << op.bit_index);
      default: wb = 1'b0;
    endcase
    if (is8) v16 = {8'h00, v8};
    r.result        = v16;
    r.flags_out     = {z, n, h, c};
    r.writes_result = wb;
    return r;
  endfunction

  // Operand with corner values in both bytes more often than chance
  function automatic logic [15:0] pick_operand();
    logic [7:0] lo;
    logic [7:0] hi;
    case ($urandom_range(0, 11))
      0: lo = 8'h00;
      1: lo = 8'hFF;
      2: lo = 8'h0F;
      3: lo = 8'h80;
      4: lo = 8'h7F;
      5: lo = 8'h99;
      6: lo = 8'h9A;
      7: lo = 8'h01;
      default: lo = 8'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: hi = 8'h00;
      1: hi = 8'hFF;
      2: hi = 8'h0F;
      default: hi = 8'($urandom);
    endcase
    return {hi, lo};
  endfunction

  task automatic flag_error(input string msg);
    if (err_cnt < MAX_SHOWN) $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Drive one transaction; open a new burst with a random gap when due
  task automatic send_op(input req_item_t it, input logic typed, input rsp_item_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    issued_q.push_back('{typed, want});
    req_ch.valid     <= 1'b1;
    req_ch.opcode    <= it.opcode;
    req_ch.operand_a <= it.operand_a;
    req_ch.operand_b <= it.operand_b;
    req_ch.bit_index <= it.bit_index;
    req_ch.flags_in  <= it.flags_in;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result consumer: rotate a 16-bit ready pattern, redrawn after each pass of the inner loop
  initial begin
    logic [15:0] pat;
    int          mode;
    rsp_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      pat  = 16'($urandom);
      if (mode == 0) pat = 16'hFFFF;
      else if (mode == 1) pat = pat & 16'($urandom);
      pat[0] = 1'b1;
      for (int i = 0; i < 64; i++) begin
        @(posedge clk);
        rsp_ch.ready <= pat[i % 16];
      end
    end
  end

  // Capture accepted operations and queue their expected results
  always @(posedge clk) begin
    req_item_t   seen;
    issue_note_t note;
    if (!rst && req_ch.valid && req_ch.ready) begin
      seen.opcode    = req_ch.opcode;
      seen.operand_a = req_ch.operand_a;
      seen.operand_b = req_ch.operand_b;
      seen.bit_index = req_ch.bit_index;
      seen.flags_in  = req_ch.flags_in;
      note = issued_q.pop_front();
      due_rsp_q.push_back(note.typed ? note.want : alu_eval(seen));
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_rsp_q.size() == 0) begin
        flag_error($sformatf("unexpected result %h", rsp_ch.result));
      end else begin
        want = due_rsp_q.pop_front();
        if (rsp_ch.result !== want.result)
          flag_error($sformatf("result %h, want %h", rsp_ch.result, want.result));
        if (rsp_ch.flags_out !== want.flags_out)
          flag_error($sformatf("flags_out %b, want %b", rsp_ch.flags_out, want.flags_out));
        if (rsp_ch.writes_result !== want.writes_result)
          flag_error($sformatf("writes_result %b, want %b",
                               rsp_ch.writes_result, want.writes_result));
      end
    end
  end

  // Stimulus: reset, directed table, random operations, drain
  initial begin
    req_item_t it;
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.opcode    <= '0;
    req_ch.operand_a <= '0;
    req_ch.operand_b <= '0;
    req_ch.bit_index <= '0;
    req_ch.flags_in  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_op(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);

    for (int k = 0; k < RAND_OPS; k++) begin
      if ($urandom_range(0, 7) == 0)
        it.opcode = 6'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      else
        it.opcode = 6'($urandom_range(OP_ADD8, OP_SET));
      it.operand_a = pick_operand();
      it.operand_b = pick_operand();
      it.bit_index = 3'($urandom);
      it.flags_in  = 4'($urandom);
      send_op(it, 1'b0, '0);
    end
    req_ch.valid <= 1'b0;

    while (issued_q.size() != 0 || due_rsp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[sm83_alu_with_flags.f]
+incdir+rtl
rtl/sm83_pkg.sv
rtl/sm83_if.sv
rtl/sm83_exec.sv
rtl/sm83_alu_with_flags.sv
tb/sv/tb_top.sv
